[rtl/equal_count_bin_edges_top_assert.svh]
// Assertion macros for the equal-count bin edge block.
`ifndef EQUAL_COUNT_BIN_EDGES_TOP_ASSERT_SVH
`define EQUAL_COUNT_BIN_EDGES_TOP_ASSERT_SVH

`ifndef ASSERT_OFF
`define ECBE_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ecbe assertion failed");
`define ECBE_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ecbe assertion failed");
`else
`define ECBE_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define ECBE_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif

`endif

[rtl/ecbe_pkg.sv]
// Shared types and constants of the equal-count bin edge block.
`timescale 1ns / 1ps

package ecbe_pkg;

  localparam int CNT_W  = 32;
  localparam int TGT_W  = 6;
  localparam int EDGE_W = 11;

  localparam int MAX_FINE_BINS_DEF   = 1024;
  localparam int MAX_TARGET_BINS_DEF = 32;

  localparam logic [TGT_W-1:0] TARGET_RESET = 6'd3;

  typedef struct packed {
    logic [CNT_W-1:0] bin_count;
    logic             last_bin;
  } ecbe_bin_t;

  typedef struct packed {
    logic [EDGE_W-1:0] edge_offset;
    logic              last_edge;
  } ecbe_result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE0,
    ST_KINIT,
    ST_READ,
    ST_MUL,
    ST_CMP,
    ST_KEND,
    ST_LAST
  } ecbe_state_t;

  typedef struct packed {
    logic mul_en;
    logic sel_best;
  } ecbe_arith_ctrl_t;

  typedef struct packed {
    logic better;
    logic reach;
  } ecbe_arith_stat_t;

endpackage

[rtl/ecbe_ram.sv]
// Running-sum memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ecbe_ram #(
  parameter int AW = 10,
  parameter int DW = 42
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/ecbe_arith.sv]
// Shared arithmetic unit: scaled-sum multiply, distance to goal and compare.
`timescale 1ns / 1ps

module ecbe_arith #(
  parameter int SUM_W = 42,
  parameter int PW    = SUM_W + ecbe_pkg::TGT_W
) (
  input  logic                         clk,
  input  ecbe_pkg::ecbe_arith_ctrl_t   ctrl,
  input  logic [ecbe_pkg::TGT_W-1:0]   target,
  input  logic [SUM_W-1:0]             rdata,
  input  logic [PW-1:0]                fbest,
  input  logic [PW-1:0]                goal,
  input  logic [PW-1:0]                bestd,
  input  logic                         bestv,
  output logic [PW-1:0]                prod,
  output logic [PW-1:0]                delta,
  output ecbe_pkg::ecbe_arith_stat_t   stat
);

  logic [PW-1:0] opnd;

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod <= PW'(rdata) * PW'(target);
    end
  end

  always_comb begin
    opnd        = ctrl.sel_best ? fbest : prod;
    stat.reach  = (opnd >= goal);
    delta       = stat.reach ? (opnd - goal) : (goal - opnd);
    stat.better = !bestv || (delta < bestd);
  end

endmodule

[rtl/equal_count_bin_edges_top.sv]
// Top level of the equal-count bin edge block: load, sequencer and edge output.
//
// Each fine-bin request is taken while busy is low; a request without
// last_bin leaves the block idle at once. On the final bin the block goes
// busy, sends edge 0 in the next cycle, then walks the stored running sums
// once in increasing order for all coarse edges together, with a memory
// read, a multiply by the target and a distance compare in the one shared
// unit for each visited sum; each later edge index revisits the sum where
// the previous one stopped, and each interior edge index adds a KINIT and a
// KEND state. When the saturated target T is below two, edge 0 is followed
// directly by the final edge. Each edge appears on result for one cycle with
// result_valid high; the receiver cannot stall, so every strobe must be
// taken as it comes. The configuration write channel is always ready.
`timescale 1ns / 1ps

module equal_count_bin_edges_top #(
  parameter int MAX_FINE_BINS   = ecbe_pkg::MAX_FINE_BINS_DEF,
  parameter int MAX_TARGET_BINS = ecbe_pkg::MAX_TARGET_BINS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  ecbe_pkg::ecbe_bin_t         bin,
  output logic                        result_valid,
  output ecbe_pkg::ecbe_result_t      result,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [ecbe_pkg::TGT_W-1:0]  cfg_data
);

  localparam int AW    = $clog2(MAX_FINE_BINS);
  localparam int CW    = $clog2(MAX_FINE_BINS + 1);
  localparam int SUM_W = ecbe_pkg::CNT_W + AW;
  localparam int PW    = SUM_W + ecbe_pkg::TGT_W;

  ecbe_pkg::ecbe_state_t      state, state_next;
  ecbe_pkg::ecbe_arith_ctrl_t actrl;
  ecbe_pkg::ecbe_arith_stat_t astat;

  logic [ecbe_pkg::TGT_W-1:0] target;
  logic [ecbe_pkg::TGT_W-1:0] teff;
  logic [ecbe_pkg::TGT_W-1:0] k;
  logic [CW-1:0]              loaded;
  logic [CW-1:0]              cursor;
  logic [CW-1:0]              cur_m1;
  logic [CW-1:0]              best;
  logic [CW-1:0]              prev;
  logic [SUM_W-1:0]           total;
  logic [SUM_W-1:0]           sum_new;
  logic [SUM_W-1:0]           rdata;
  logic [PW-1:0]              goal;
  logic [PW-1:0]              fbest;
  logic [PW-1:0]              bestd;
  logic [PW-1:0]              prod;
  logic [PW-1:0]              delta;
  logic                       bestv;
  logic                       accept;
  logic                       room;
  logic                       stop;
  logic                       emit_mid;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ecbe_pkg::ST_IDLE);
  assign accept    = start && !busy;
  assign room      = (loaded < CW'(MAX_FINE_BINS));
  assign sum_new   = total + SUM_W'(bin.bin_count);
  assign cur_m1    = cursor - CW'(1);
  assign teff      = (target > ecbe_pkg::TGT_W'(MAX_TARGET_BINS)) ?
                     ecbe_pkg::TGT_W'(MAX_TARGET_BINS) : target;
  assign stop      = astat.reach || (cursor == loaded);
  assign emit_mid  = (best > prev) && (best < loaded);

  ecbe_ram #(
    .AW (AW),
    .DW (SUM_W)
  ) u_ram (
    .clk   (clk),
    .we    (accept && room),
    .waddr (loaded[AW-1:0]),
    .wdata (sum_new),
    .raddr (cur_m1[AW-1:0]),
    .rdata (rdata)
  );

  ecbe_arith #(
    .SUM_W (SUM_W),
    .PW    (PW)
  ) u_arith (
    .clk    (clk),
    .ctrl   (actrl),
    .target (teff),
    .rdata  (rdata),
    .fbest  (fbest),
    .goal   (goal),
    .bestd  (bestd),
    .bestv  (bestv),
    .prod   (prod),
    .delta  (delta),
    .stat   (astat)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ecbe_pkg::ST_IDLE: begin
        if (accept && bin.last_bin) begin
          state_next = ecbe_pkg::ST_EDGE0;
        end
      end
      ecbe_pkg::ST_EDGE0: begin
        state_next = (teff > ecbe_pkg::TGT_W'(1)) ? ecbe_pkg::ST_KINIT : ecbe_pkg::ST_LAST;
      end
      ecbe_pkg::ST_KINIT: state_next = ecbe_pkg::ST_READ;
      ecbe_pkg::ST_READ:  state_next = ecbe_pkg::ST_MUL;
      ecbe_pkg::ST_MUL:   state_next = ecbe_pkg::ST_CMP;
      ecbe_pkg::ST_CMP: begin
        state_next = stop ? ecbe_pkg::ST_KEND : ecbe_pkg::ST_READ;
      end
      ecbe_pkg::ST_KEND: begin
        state_next = ((k + ecbe_pkg::TGT_W'(1)) < teff) ? ecbe_pkg::ST_KINIT :
                     ecbe_pkg::ST_LAST;
      end
      ecbe_pkg::ST_LAST:  state_next = ecbe_pkg::ST_IDLE;
      default:            state_next = ecbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    result_valid       = 1'b0;
    result.edge_offset = '0;
    result.last_edge   = 1'b0;
    actrl.mul_en       = 1'b0;
    actrl.sel_best     = 1'b0;
    unique case (state)
      ecbe_pkg::ST_EDGE0: result_valid = 1'b1;
      ecbe_pkg::ST_KINIT: actrl.sel_best = 1'b1;
      ecbe_pkg::ST_MUL:   actrl.mul_en = 1'b1;
      ecbe_pkg::ST_KEND: begin
        result_valid       = emit_mid;
        result.edge_offset = ecbe_pkg::EDGE_W'(best);
      end
      ecbe_pkg::ST_LAST: begin
        result_valid       = 1'b1;
        result.edge_offset = ecbe_pkg::EDGE_W'(loaded);
        result.last_edge   = 1'b1;
      end
      default: begin
        result_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ecbe_pkg::ST_IDLE;
      target <= ecbe_pkg::TARGET_RESET;
      loaded <= '0;
      total  <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        target <= cfg_data;
      end
      if (accept && room) begin
        loaded <= loaded + CW'(1);
        total  <= sum_new;
      end
      if (state == ecbe_pkg::ST_LAST) begin
        loaded <= '0;
        total  <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      ecbe_pkg::ST_EDGE0: begin
        k      <= ecbe_pkg::TGT_W'(1);
        goal   <= PW'(total);
        cursor <= CW'(1);
        best   <= CW'(1);
        prev   <= '0;
        bestv  <= 1'b0;
      end
      ecbe_pkg::ST_KINIT: begin
        if (bestv) begin
          bestd <= delta;
        end
      end
      ecbe_pkg::ST_CMP: begin
        if (astat.better) begin
          best  <= cursor;
          bestd <= delta;
          fbest <= prod;
          bestv <= 1'b1;
        end
        if (!stop) begin
          cursor <= cursor + CW'(1);
        end
      end
      ecbe_pkg::ST_KEND: begin
        if (emit_mid) begin
          prev <= best;
        end
        k    <= k + ecbe_pkg::TGT_W'(1);
        goal <= goal + PW'(total);
      end
      default: begin
      end
    endcase
  end

`include "equal_count_bin_edges_top_assert.svh"

  `ECBE_ASSERT_NXT(a_final_then_idle, clk, rst, result_valid && result.last_edge, !busy)
  `ECBE_ASSERT_NXT(a_mid_bin_stays_idle, clk, rst, accept && !bin.last_bin, !busy && !result_valid)
  `ECBE_ASSERT_NXT(a_last_bin_edge0, clk, rst, accept && bin.last_bin, result_valid && result.edge_offset == '0 && !result.last_edge)
  `ECBE_ASSERT_IMP(a_result_while_busy, clk, rst, result_valid, busy)

endmodule
